// File: rtl/mlr_pkg.sv
// shared constants for the midpoint line rasteriser
// no dependencies; imported by every module of the block
package mlr_pkg;

	// default coordinate width of the endpoint and pixel fields
	localparam int COORD_BITS_DEF = 6;

	// number of classified lines the queue between front and back can hold
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int OCT_BITS = 3;

	// octant codes (region minus one)
	localparam logic [OCT_BITS-1:0] OCT_XMAJ_PX_PY = 3'd0;
	localparam logic [OCT_BITS-1:0] OCT_YMAJ_PX_PY = 3'd1;
	localparam logic [OCT_BITS-1:0] OCT_YMAJ_NX_PY = 3'd2;
	localparam logic [OCT_BITS-1:0] OCT_XMAJ_NX_PY = 3'd3;
	localparam logic [OCT_BITS-1:0] OCT_XMAJ_NX_NY = 3'd4;
	localparam logic [OCT_BITS-1:0] OCT_YMAJ_NX_NY = 3'd5;
	localparam logic [OCT_BITS-1:0] OCT_YMAJ_PX_NY = 3'd6;
	localparam logic [OCT_BITS-1:0] OCT_XMAJ_PX_NY = 3'd7;

endpackage

// File: rtl/mlr_front.sv
// front end: classifies one line segment into octant, major/minor deltas and
// decision terms; depends on mlr_pkg
module mlr_front #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic [COORD_BITS-1:0]        start_x,
	input  logic [COORD_BITS-1:0]        start_y,
	input  logic [COORD_BITS-1:0]        end_x,
	input  logic [COORD_BITS-1:0]        end_y,
	output logic [mlr_pkg::OCT_BITS-1:0] octant,
	output logic                         sx_neg,
	output logic                         sy_neg,
	output logic                         x_major,
	output logic [COORD_BITS-1:0]        major_len,
	output logic [COORD_BITS+1:0]        d_init,
	output logic [COORD_BITS+1:0]        inc_axis,
	output logic [COORD_BITS+1:0]        inc_diag
);
	import mlr_pkg::*;

	localparam int N = COORD_BITS;

	logic [N:0]   dx, dy;
	logic [N:0]   adx_w, ady_w;
	logic [N-1:0] adx, ady, minor_len;

	always_comb begin
		dx = {end_x[N-1], end_x} - {start_x[N-1], start_x};
		dy = {end_y[N-1], end_y} - {start_y[N-1], start_y};
		adx_w = dx[N] ? (~dx + 1'b1) : dx;
		ady_w = dy[N] ? (~dy + 1'b1) : dy;
		adx = adx_w[N-1:0];
		ady = ady_w[N-1:0];
		sx_neg = dx[N];
		sy_neg = dy[N];
		x_major = (adx >= ady);
		major_len = x_major ? adx : ady;
		minor_len = x_major ? ady : adx;
		inc_axis = {1'b0, minor_len, 1'b0};
		d_init = {1'b0, minor_len, 1'b0} - {2'b00, major_len};
		inc_diag = {1'b0, minor_len, 1'b0} - {1'b0, major_len, 1'b0};
	end

	// region decode
	always_comb begin
		unique case ({x_major, sx_neg, sy_neg})
			3'b100:  octant = OCT_XMAJ_PX_PY;
			3'b101:  octant = OCT_XMAJ_PX_NY;
			3'b110:  octant = OCT_XMAJ_NX_PY;
			3'b111:  octant = OCT_XMAJ_NX_NY;
			3'b000:  octant = OCT_YMAJ_PX_PY;
			3'b001:  octant = OCT_YMAJ_PX_NY;
			3'b010:  octant = OCT_YMAJ_NX_PY;
			default: octant = OCT_YMAJ_NX_NY;
		endcase
	end

endmodule

// File: rtl/mlr_queue.sv
// small register queue carrying classified lines from front to back
// depends on mlr_pkg for its default depth
module mlr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import mlr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/mlr_back.sv
// back end: midpoint stepper walking one line a pixel per beat into an
// output register; depends on mlr_pkg
module mlr_back #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// line from the queue
	input  logic                         line_valid,
	output logic                         line_pop,
	input  logic [COORD_BITS-1:0]        line_x0,
	input  logic [COORD_BITS-1:0]        line_y0,
	input  logic [mlr_pkg::OCT_BITS-1:0] line_octant,
	input  logic                         line_sx_neg,
	input  logic                         line_sy_neg,
	input  logic                         line_x_major,
	input  logic [COORD_BITS-1:0]        line_major_len,
	input  logic [COORD_BITS+1:0]        line_d_init,
	input  logic [COORD_BITS+1:0]        line_inc_axis,
	input  logic [COORD_BITS+1:0]        line_inc_diag,
	// pixel channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COORD_BITS-1:0]        pixel_x,
	output logic [COORD_BITS-1:0]        pixel_y,
	output logic [mlr_pkg::OCT_BITS-1:0] octant,
	output logic                         diagonal_step,
	output logic                         last_pixel
);
	import mlr_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int DW = COORD_BITS + 2;

	logic          busy_q, out_valid_q;
	logic [N-1:0]  remain_q;
	logic [DW-1:0] d_q, inc_axis_q, inc_diag_q;
	logic          sx_neg_q, sy_neg_q, x_major_q;
	logic [N-1:0]  x_q, y_q;
	logic [OCT_BITS-1:0] oct_q;
	logic          diag_q, last_q;

	logic          advance, load, step, take_diag;
	logic [N-1:0]  step_x, step_y, x_next, y_next;

	assign advance   = !out_valid_q || out_ready;
	assign load      = advance && !busy_q && line_valid;
	assign step      = advance && busy_q;
	assign line_pop  = load;

	// d > 0 takes the diagonal
	assign take_diag = !d_q[DW-1] && (d_q != '0);
	assign step_x    = sx_neg_q ? '1 : N'(1);
	assign step_y    = sy_neg_q ? '1 : N'(1);
	assign x_next    = (take_diag || x_major_q) ? x_q + step_x : x_q;
	assign y_next    = (take_diag || !x_major_q) ? y_q + step_y : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			remain_q    <= '0;
		end else begin
			if (load) begin
				busy_q   <= (line_major_len != '0);
				remain_q <= line_major_len;
			end else if (step) begin
				busy_q   <= (remain_q != N'(1));
				remain_q <= remain_q - 1'b1;
			end
			if (load || step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_q        <= line_d_init;
			inc_axis_q <= line_inc_axis;
			inc_diag_q <= line_inc_diag;
			sx_neg_q   <= line_sx_neg;
			sy_neg_q   <= line_sy_neg;
			x_major_q  <= line_x_major;
			x_q        <= line_x0;
			y_q        <= line_y0;
			oct_q      <= line_octant;
			diag_q     <= 1'b0;
			last_q     <= (line_major_len == '0);
		end else if (step) begin
			d_q    <= d_q + (take_diag ? inc_diag_q : inc_axis_q);
			x_q    <= x_next;
			y_q    <= y_next;
			diag_q <= take_diag;
			last_q <= (remain_q == N'(1));
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = x_q;
	assign pixel_y       = y_q;
	assign octant        = oct_q;
	assign diagonal_step = diag_q;
	assign last_pixel    = last_q;

endmodule

// File: rtl/midpoint_line_rasterizer_top.sv
// top level of the eight-octant midpoint line rasteriser
// depends on mlr_pkg, mlr_front, mlr_queue and mlr_back

// A line segment beat on the input channel carries two signed endpoints. The
// block answers with |major delta| + 1 pixel beats, start point first and end
// point last (flagged by last_pixel). Each pixel beat is tagged with the
// octant of the line and with whether a diagonal move reached it. The front
// end classifies a line in the cycle it is taken and parks it in a two-deep
// queue, so up to two lines can be accepted ahead of the one being drawn. A
// line taken while the block is idle is written into the queue and then
// loaded into the back end's output register, which shows its first pixel.
// The back end's stepper gives one pixel per cycle while the output side
// takes them; |major delta| + 1 is at most 2^COORD_BITS. A queued line loads
// as the last pixel of the line before it is taken, with no gap between them.
// There is no configuration and nothing to clear after reset.
module midpoint_line_rasterizer_top #(
	parameter int COORD_BITS  = mlr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = mlr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// segment channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	// pixel channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_BITS-1:0]        pixel_x,
	output logic signed [COORD_BITS-1:0]        pixel_y,
	output logic        [mlr_pkg::OCT_BITS-1:0] octant,
	output logic                                diagonal_step,
	output logic                                last_pixel
);
	import mlr_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int DW = COORD_BITS + 2;
	// start point, octant, three direction flags, major length, decision terms
	localparam int LW = 2 * N + OCT_BITS + 3 + N + 3 * DW;

	// classified line from the front end
	logic [OCT_BITS-1:0] f_octant;
	logic                f_sx_neg, f_sy_neg, f_x_major;
	logic [N-1:0]        f_major_len;
	logic [DW-1:0]       f_d_init, f_inc_axis, f_inc_diag;

	// queue
	logic          q_full, q_not_empty, q_pop, q_push;
	logic [LW-1:0] q_in, q_out;

	// line as seen by the back end
	logic [N-1:0]        b_x0, b_y0, b_major_len;
	logic [OCT_BITS-1:0] b_octant;
	logic                b_sx_neg, b_sy_neg, b_x_major;
	logic [DW-1:0]       b_d_init, b_inc_axis, b_inc_diag;

	// unsigned views of the pixel fields
	logic [N-1:0] px_u, py_u;

	mlr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.octant    (f_octant),
		.sx_neg    (f_sx_neg),
		.sy_neg    (f_sy_neg),
		.x_major   (f_x_major),
		.major_len (f_major_len),
		.d_init    (f_d_init),
		.inc_axis  (f_inc_axis),
		.inc_diag  (f_inc_diag)
	);

	// a segment beat is taken whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_in     = {start_x, start_y, f_octant, f_sx_neg, f_sy_neg, f_x_major,
		f_major_len, f_d_init, f_inc_axis, f_inc_diag};

	mlr_queue #(
		.WIDTH (LW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_out)
	);

	assign {b_x0, b_y0, b_octant, b_sx_neg, b_sy_neg, b_x_major,
		b_major_len, b_d_init, b_inc_axis, b_inc_diag} = q_out;

	mlr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.line_valid     (q_not_empty),
		.line_pop       (q_pop),
		.line_x0        (b_x0),
		.line_y0        (b_y0),
		.line_octant    (b_octant),
		.line_sx_neg    (b_sx_neg),
		.line_sy_neg    (b_sy_neg),
		.line_x_major   (b_x_major),
		.line_major_len (b_major_len),
		.line_d_init    (b_d_init),
		.line_inc_axis  (b_inc_axis),
		.line_inc_diag  (b_inc_diag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_x        (px_u),
		.pixel_y        (py_u),
		.octant         (octant),
		.diagonal_step  (diagonal_step),
		.last_pixel     (last_pixel)
	);

	assign pixel_x = px_u;
	assign pixel_y = py_u;

endmodule
